// ----- design/aarm_pkg.sv -----
// Shared types, constants and arithmetic helpers for the axis-angle rotation block.
package aarm_pkg;

    // Field widths and number formats.
    localparam int ANGLE_BITS  = 16;
    localparam int FRAC_BITS   = 15;
    localparam int PHASE_W     = 16;
    localparam int AXIS_W      = 16;
    localparam int OUT_W       = 17;
    localparam int NUM_ELEMS   = 9;

    // CORDIC datapath: Q30 values with headroom for sign and growth.
    localparam int CORDIC_FRAC = 30;
    localparam int CW          = 34;
    localparam int STEPS       = 30;
    localparam int STEP_W      = $clog2(STEPS);

    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
    localparam logic [30:0]          HALF_PI_Q30 = 31'd1686629713;

    // Product widths in the matrix stages.
    localparam int PP_W   = 2 * AXIS_W;
    localparam int WIDE_W = 64;

    localparam logic signed [WIDE_W-1:0] ROUND_HALF = WIDE_W'(64'sd1 <<< (CORDIC_FRAC - 1));
    localparam logic signed [WIDE_W-1:0] OUT_MAX    = WIDE_W'(64'sd65535);
    localparam logic signed [WIDE_W-1:0] OUT_MIN    = -WIDE_W'(64'sd65536);

    // Quadrant codes taken from the top two phase bits.
    typedef enum logic [1:0] {
        QUAD_FIRST  = 2'd0,
        QUAD_SECOND = 2'd1,
        QUAD_THIRD  = 2'd2,
        QUAD_FOURTH = 2'd3
    } t_quad;

    // Axis components and quadrant ride along with the rotation.
    typedef struct packed {
        logic signed [AXIS_W-1:0] ax;
        logic signed [AXIS_W-1:0] ay;
        logic signed [AXIS_W-1:0] az;
        t_quad                    quad;
    } t_carry;

    // Data handed from one CORDIC cell to the next.
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        t_carry               carry;
    } t_cord;

    // Arctangent of 2^-i in Q30.
    function automatic logic signed [CW-1:0] atan_q30(input logic [STEP_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            5'd24:   v = 32'h0000003F;
            5'd25:   v = 32'h0000001F;
            5'd26:   v = 32'h0000000F;
            5'd27:   v = 32'h00000008;
            5'd28:   v = 32'h00000004;
            5'd29:   v = 32'h00000002;
            default: v = 32'h00000000;
        endcase
        return CW'(v);
    endfunction

    // Drop the extra fraction bits of the quadratic term, add the linear term,
    // round half up to the output scale and saturate.
    function automatic logic signed [OUT_W-1:0] elem_round(
        input logic signed [WIDE_W-1:0] pq,
        input logic signed [WIDE_W-1:0] lin
    );
        logic signed [WIDE_W-1:0] sum;
        logic signed [WIDE_W-1:0] v;
        sum = (pq >>> FRAC_BITS) + lin + ROUND_HALF;
        v   = sum >>> CORDIC_FRAC;
        if (v > OUT_MAX) begin
            v = OUT_MAX;
        end else if (v < OUT_MIN) begin
            v = OUT_MIN;
        end
        return v[OUT_W-1:0];
    endfunction

endpackage

// ----- design/axis_angle_rotation_matrix.sv -----
// Top level: axis and angle in, 3x3 rotation matrix out.
// The block accepts one item per clock cycle while the output is not stalled, and passes each
// item through one entry stage that scales the phase into a Q30 angle, a row of 30
// CORDIC cells that each perform one micro-rotation and pass the item to the next cell,
// and three matrix stages (products, wide products, rounding with output register).
// Every stage stalls only when it is full and its successor cannot take its item, so
// empty slots close up and new items keep entering while a finished matrix waits at the
// output. Elements are Q2.15, rounded half up and saturated to the 17-bit range.
module axis_angle_rotation_matrix
    import aarm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [AXIS_W-1:0] i_axis_x,
    input  logic signed [AXIS_W-1:0] i_axis_y,
    input  logic signed [AXIS_W-1:0] i_axis_z,
    input  logic [PHASE_W-1:0]      i_angle_phase,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [OUT_W-1:0] o_elem_r1c1,
    output logic signed [OUT_W-1:0] o_elem_r1c2,
    output logic signed [OUT_W-1:0] o_elem_r1c3,
    output logic signed [OUT_W-1:0] o_elem_r2c1,
    output logic signed [OUT_W-1:0] o_elem_r2c2,
    output logic signed [OUT_W-1:0] o_elem_r2c3,
    output logic signed [OUT_W-1:0] o_elem_r3c1,
    output logic signed [OUT_W-1:0] o_elem_r3c2,
    output logic signed [OUT_W-1:0] o_elem_r3c3
);

    localparam int REM_W = ANGLE_BITS - 2;
    localparam int ZP_W  = REM_W + 31;

    logic                    r_valid;
    t_cord                   r_data;
    t_cord                   n_data;
    logic [ANGLE_BITS-1:0]   w_phase;
    logic [REM_W-1:0]        w_rem;
    logic [ZP_W-1:0]         w_zprod;

    logic                    w_valid [STEPS+1];
    logic                    w_ready [STEPS+1];
    t_cord                   w_data  [STEPS+1];
    logic signed [OUT_W-1:0] w_elem  [NUM_ELEMS];

    // Entry stage: split the phase into quadrant and remainder, scale to radians.
    always_comb begin
        w_phase            = ANGLE_BITS'(i_angle_phase);
        w_rem              = w_phase[REM_W-1:0];
        w_zprod            = ZP_W'(w_rem) * ZP_W'(HALF_PI_Q30);
        n_data.x           = CORDIC_GAIN;
        n_data.y           = '0;
        n_data.z           = CW'(w_zprod >> REM_W);
        n_data.carry.ax    = i_axis_x;
        n_data.carry.ay    = i_axis_y;
        n_data.carry.az    = i_axis_z;
        n_data.carry.quad  = t_quad'(w_phase[ANGLE_BITS-1 -: 2]);
    end

    assign o_ready = !r_valid || w_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign w_valid[0] = r_valid;
    assign w_data[0]  = r_data;

    // Row of CORDIC cells, one micro-rotation each.
    for (genvar k = 0; k < STEPS; k++) begin : g_cell
        aarm_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_data  (w_data[k]),
            .i_shift (STEP_W'(k)),
            .i_atan  (atan_q30(STEP_W'(k))),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_data  (w_data[k+1])
        );
    end

    // Matrix stages.
    aarm_matrix_tail u_tail (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[STEPS]),
        .o_ready (w_ready[STEPS]),
        .i_data  (w_data[STEPS]),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_elem  (w_elem)
    );

    assign o_elem_r1c1 = w_elem[0];
    assign o_elem_r1c2 = w_elem[1];
    assign o_elem_r1c3 = w_elem[2];
    assign o_elem_r2c1 = w_elem[3];
    assign o_elem_r2c2 = w_elem[4];
    assign o_elem_r2c3 = w_elem[5];
    assign o_elem_r3c1 = w_elem[6];
    assign o_elem_r3c2 = w_elem[7];
    assign o_elem_r3c3 = w_elem[8];

endmodule

// ----- design/aarm_cordic_cell.sv -----
// One CORDIC rotation cell: a single micro-rotation with its own item register.
module aarm_cordic_cell
    import aarm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_cord               i_data,
    input  logic [STEP_W-1:0]   i_shift,
    input  logic signed [CW-1:0] i_atan,
    output logic                o_valid,
    input  logic                i_ready,
    output t_cord               o_data
);

    logic  r_valid;
    t_cord r_data;
    t_cord n_data;
    logic  w_load;

    logic signed [CW-1:0] w_dx;
    logic signed [CW-1:0] w_dy;

    // The cell takes a new item when it is empty or its item moves on.
    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    // Rotate toward zero residual angle; both updates use the old x and y.
    always_comb begin
        w_dx   = i_data.y >>> i_shift;
        w_dy   = i_data.x >>> i_shift;
        n_data = i_data;
        if (!i_data.z[CW-1]) begin
            n_data.x = i_data.x - w_dx;
            n_data.y = i_data.y + w_dy;
            n_data.z = i_data.z - i_atan;
        end else begin
            n_data.x = i_data.x + w_dx;
            n_data.y = i_data.y - w_dy;
            n_data.z = i_data.z + i_atan;
        end
    end

    // Occupancy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Item register.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- design/aarm_matrix_tail.sv -----
// Quadrant fold, products and rounding that turn sine and cosine into the nine elements.
module aarm_matrix_tail
    import aarm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  t_cord                   i_data,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [OUT_W-1:0] o_elem [NUM_ELEMS]
);

    // Stage 1: cosine, sine, one minus cosine, axis pair products.
    logic                     r1_valid;
    logic signed [CW-1:0]     r1_c;
    logic signed [CW-1:0]     r1_s;
    logic signed [CW-1:0]     r1_om;
    logic signed [AXIS_W-1:0] r1_axis [3];
    logic signed [PP_W-1:0]   r1_pp [6];

    // Stage 2: wide products.
    logic                     r2_valid;
    logic signed [WIDE_W-1:0] r2_pq [6];
    logic signed [WIDE_W-1:0] r2_ls [3];
    logic signed [WIDE_W-1:0] r2_cd;

    // Stage 3: output register.
    logic                     r3_valid;
    logic signed [OUT_W-1:0]  r3_elem [NUM_ELEMS];

    logic                 w_rdy1;
    logic                 w_rdy2;
    logic                 w_rdy3;
    logic signed [CW-1:0] n_c;
    logic signed [CW-1:0] n_s;

    // Each stage moves when it is empty or the next one can take its item.
    assign w_rdy3  = !r3_valid || i_ready;
    assign w_rdy2  = !r2_valid || w_rdy3;
    assign w_rdy1  = !r1_valid || w_rdy2;
    assign o_ready = w_rdy1;

    // Fold the first-quadrant result into the full turn.
    always_comb begin
        case (i_data.carry.quad)
            QUAD_FIRST: begin
                n_c = i_data.x;
                n_s = i_data.y;
            end
            QUAD_SECOND: begin
                n_c = -i_data.y;
                n_s = i_data.x;
            end
            QUAD_THIRD: begin
                n_c = -i_data.x;
                n_s = -i_data.y;
            end
            default: begin
                n_c = i_data.y;
                n_s = -i_data.x;
            end
        endcase
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r1_valid <= i_valid;
            end
            if (w_rdy2) begin
                r2_valid <= r1_valid;
            end
            if (w_rdy3) begin
                r3_valid <= r2_valid;
            end
        end
    end

    // Stage 1 payload: pairs are xx, yy, zz, xy, xz, yz.
    always_ff @(posedge i_clk) begin
        if (i_valid && w_rdy1) begin
            r1_c       <= n_c;
            r1_s       <= n_s;
            r1_om      <= (CW'(64'sd1 <<< CORDIC_FRAC)) - n_c;
            r1_axis[0] <= i_data.carry.ax;
            r1_axis[1] <= i_data.carry.ay;
            r1_axis[2] <= i_data.carry.az;
            r1_pp[0]   <= PP_W'(i_data.carry.ax) * PP_W'(i_data.carry.ax);
            r1_pp[1]   <= PP_W'(i_data.carry.ay) * PP_W'(i_data.carry.ay);
            r1_pp[2]   <= PP_W'(i_data.carry.az) * PP_W'(i_data.carry.az);
            r1_pp[3]   <= PP_W'(i_data.carry.ax) * PP_W'(i_data.carry.ay);
            r1_pp[4]   <= PP_W'(i_data.carry.ax) * PP_W'(i_data.carry.az);
            r1_pp[5]   <= PP_W'(i_data.carry.ay) * PP_W'(i_data.carry.az);
        end
    end

    // Stage 2 payload: quadratic terms, axis times sine, scaled cosine.
    always_ff @(posedge i_clk) begin
        if (r1_valid && w_rdy2) begin
            for (int k = 0; k < 6; k++) begin
                r2_pq[k] <= WIDE_W'(r1_pp[k]) * WIDE_W'(r1_om);
            end
            for (int k = 0; k < 3; k++) begin
                r2_ls[k] <= WIDE_W'(r1_axis[k]) * WIDE_W'(r1_s);
            end
            r2_cd <= WIDE_W'(r1_c) <<< FRAC_BITS;
        end
    end

    // Stage 3 payload: combine, round and saturate each element.
    always_ff @(posedge i_clk) begin
        if (r2_valid && w_rdy3) begin
            r3_elem[0] <= elem_round(r2_pq[0], r2_cd);
            r3_elem[1] <= elem_round(r2_pq[3], r2_ls[2]);
            r3_elem[2] <= elem_round(r2_pq[4], -r2_ls[1]);
            r3_elem[3] <= elem_round(r2_pq[3], -r2_ls[2]);
            r3_elem[4] <= elem_round(r2_pq[1], r2_cd);
            r3_elem[5] <= elem_round(r2_pq[5], r2_ls[0]);
            r3_elem[6] <= elem_round(r2_pq[4], r2_ls[1]);
            r3_elem[7] <= elem_round(r2_pq[5], -r2_ls[0]);
            r3_elem[8] <= elem_round(r2_pq[2], r2_cd);
        end
    end

    assign o_valid = r3_valid;
    assign o_elem  = r3_elem;

endmodule

// ----- design/aarm_checker.sv -----
// Port-level checks for the rotation block, bound to its top level.
module aarm_checker
    import aarm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    o_ready,
    input  logic                    o_valid,
    input  logic                    i_ready,
    input  logic signed [OUT_W-1:0] o_elem_r1c1,
    input  logic signed [OUT_W-1:0] o_elem_r2c2,
    input  logic signed [OUT_W-1:0] o_elem_r3c3
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result item shown right after reset");

    // A stalled result item stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result item dropped while stalled");

    // A stalled result item keeps its diagonal values.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_elem_r1c1) && $stable(o_elem_r2c2)
            && $stable(o_elem_r3c3))
        else $error("result item changed while stalled");

    // Input is refused only when every stage is full and the output is stalled.
    a_refuse_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input refused with room in the pipeline");

endmodule

bind axis_angle_rotation_matrix aarm_checker u_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench for the axis-angle to rotation matrix block.
`timescale 1ns / 100ps

module testbench;
    import aarm_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 1930;
    localparam int DRAIN_CYCLES  = 60;
    localparam int REPORT_LIMIT  = 10;

    localparam longint GAIN_Q30    = 64'sd652032874;
    localparam longint QUARTER_Q30 = 64'sd1686629713;
    localparam longint ONE_Q30     = 64'sd1 <<< 30;

    // One axis and angle as the sender presents it.
    typedef struct {
        logic signed [AXIS_W-1:0] ax;
        logic signed [AXIS_W-1:0] ay;
        logic signed [AXIS_W-1:0] az;
        logic [PHASE_W-1:0]       phase;
        bit                       drain_first;
    } t_axis_item;

    // Nine matrix elements, row by row.
    typedef logic [NUM_ELEMS-1:0][OUT_W-1:0] t_matrix;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic signed [AXIS_W-1:0] i_axis_x = '0;
    logic signed [AXIS_W-1:0] i_axis_y = '0;
    logic signed [AXIS_W-1:0] i_axis_z = '0;
    logic [PHASE_W-1:0]       i_angle_phase = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic signed [OUT_W-1:0]  o_elem_r1c1, o_elem_r1c2, o_elem_r1c3;
    logic signed [OUT_W-1:0]  o_elem_r2c1, o_elem_r2c2, o_elem_r2c3;
    logic signed [OUT_W-1:0]  o_elem_r3c1, o_elem_r3c2, o_elem_r3c3;

    t_axis_item axis_queue[$];
    t_matrix    predicted_matrices[$];
    int         total_items = 1;
    int         items_sent = 0;
    int         matrices_checked = 0;
    int         saturated_elems = 0;
    int         mismatches = 0;
    int         cycle_count = 0;

    // Arctangent of 2^-i in Q30 for each micro-rotation.
    longint atan_steps [30] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
    };

    axis_angle_rotation_matrix i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_axis_x      (i_axis_x),
        .i_axis_y      (i_axis_y),
        .i_axis_z      (i_axis_z),
        .i_angle_phase (i_angle_phase),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_elem_r1c1   (o_elem_r1c1),
        .o_elem_r1c2   (o_elem_r1c2),
        .o_elem_r1c3   (o_elem_r1c3),
        .o_elem_r2c1   (o_elem_r2c1),
        .o_elem_r2c2   (o_elem_r2c2),
        .o_elem_r2c3   (o_elem_r2c3),
        .o_elem_r3c1   (o_elem_r3c1),
        .o_elem_r3c2   (o_elem_r3c2),
        .o_elem_r3c3   (o_elem_r3c3)
    );

    always #5 i_clk = ~i_clk;

    // One element: quadratic term reduced to the linear scale, rounded half up, saturated.
    function automatic logic [OUT_W-1:0] matrix_entry(input longint ai, input longint aj,
                                                      input longint om, input longint lin);
        longint quad_term;
        longint v;
        quad_term = (ai * aj * om) >>> FRAC_BITS;
        v = (quad_term + lin + (64'sd1 <<< 29)) >>> 30;
        if (v > OUT_MAX) begin
            v = OUT_MAX;
        end else if (v < OUT_MIN) begin
            v = OUT_MIN;
        end
        return v[OUT_W-1:0];
    endfunction

    // Predicts the rotation matrix for one axis and angle.
    function automatic t_matrix rotation_matrix(input logic signed [AXIS_W-1:0] ax,
                                                input logic signed [AXIS_W-1:0] ay,
                                                input logic signed [AXIS_W-1:0] az,
                                                input logic [PHASE_W-1:0] phase);
        t_quad   quadrant;
        longint  x, y, z, dx, dy, c, s, om, cd, vx, vy, vz;
        t_matrix m;
        quadrant = t_quad'(phase[ANGLE_BITS-1 -: 2]);
        z = (longint'(phase[ANGLE_BITS-3:0]) * QUARTER_Q30) >>> (ANGLE_BITS - 2);
        x = GAIN_Q30;
        y = 0;
        // CORDIC in rotation mode, both updates from the old x and y.
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - atan_steps[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + atan_steps[i];
            end
        end
        // Fold the first-quadrant result out to the real quadrant.
        case (quadrant)
            QUAD_FIRST: begin
                c = x;
                s = y;
            end
            QUAD_SECOND: begin
                c = -y;
                s = x;
            end
            QUAD_THIRD: begin
                c = -x;
                s = -y;
            end
            default: begin
                c = y;
                s = -x;
            end
        endcase
        om = ONE_Q30 - c;
        cd = c * (64'sd1 <<< FRAC_BITS);
        vx = longint'(ax);
        vy = longint'(ay);
        vz = longint'(az);
        m[0] = matrix_entry(vx, vx, om, cd);
        m[1] = matrix_entry(vx, vy, om, vz * s);
        m[2] = matrix_entry(vx, vz, om, -(vy * s));
        m[3] = matrix_entry(vy, vx, om, -(vz * s));
        m[4] = matrix_entry(vy, vy, om, cd);
        m[5] = matrix_entry(vy, vz, om, vx * s);
        m[6] = matrix_entry(vz, vx, om, vy * s);
        m[7] = matrix_entry(vz, vy, om, -(vx * s));
        m[8] = matrix_entry(vz, vz, om, cd);
        return m;
    endfunction

    // Idle percentage per side: sender light then heavy, then no idling at all.
    function automatic int idle_pct(input bit sender);
        int stage;
        stage = (items_sent * 3) / total_items;
        if (stage == 0) begin
            return sender ? 24 : 74;
        end else if (stage == 1) begin
            return sender ? 74 : 24;
        end
        return 0;
    endfunction

    task automatic add_item(input int ax, input int ay, input int az, input int phase,
                            input bit drain_first);
        t_axis_item item;
        item.ax = ax[AXIS_W-1:0];
        item.ay = ay[AXIS_W-1:0];
        item.az = az[AXIS_W-1:0];
        item.phase = phase[PHASE_W-1:0];
        item.drain_first = drain_first;
        axis_queue.push_back(item);
    endtask

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    // An extreme component: -32768, -1, 0, 1 or 32767; most random items use a normalized axis.
    function automatic int extreme_component();
        case ($urandom_range(4))
            0: return -32768;
            1: return -1;
            2: return 0;
            3: return 1;
            default: return 32767;
        endcase
    endfunction

    // Driver: presents queued items and predicts the matrix of each accepted item.
    always @(posedge i_clk) begin
        bit take_next;
        t_axis_item item;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                predicted_matrices.push_back(
                    rotation_matrix(i_axis_x, i_axis_y, i_axis_z, i_angle_phase));
                items_sent++;
            end
            if (!i_valid || o_ready) begin
                take_next = 1'b0;
                if (axis_queue.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
                    // A drain point holds the item back until the pipeline is empty.
                    take_next = !axis_queue[0].drain_first ||
                                (!i_valid && predicted_matrices.size() == 0);
                end
                if (take_next) begin
                    item = axis_queue.pop_front();
                    i_axis_x <= item.ax;
                    i_axis_y <= item.ay;
                    i_axis_z <= item.az;
                    i_angle_phase <= item.phase;
                end
                i_valid <= take_next;
            end
        end
    end

    // Receiver stalls.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_ready <= ($urandom_range(99) >= idle_pct(1'b0));
        end
    end

    // Monitor: compares each accepted matrix with the oldest prediction.
    always @(posedge i_clk) begin
        t_matrix got;
        t_matrix want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_elem_r3c3, o_elem_r3c2, o_elem_r3c1,
                   o_elem_r2c3, o_elem_r2c2, o_elem_r2c1,
                   o_elem_r1c3, o_elem_r1c2, o_elem_r1c1};
            if (predicted_matrices.size() == 0) begin
                note_mismatch("matrix arrived with no item outstanding");
            end else begin
                want = predicted_matrices.pop_front();
                matrices_checked++;
                for (int k = 0; k < NUM_ELEMS; k++) begin
                    if (want[k] == 17'h0FFFF || want[k] == 17'h10000) begin
                        saturated_elems++;
                    end
                    if (got[k] !== want[k]) begin
                        note_mismatch($sformatf("matrix %0d r%0dc%0d expected %0d got %0d",
                                                matrices_checked, k / 3 + 1, k % 3 + 1,
                                                $signed(want[k]), $signed(got[k])));
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    initial begin
        real rx, ry, rz, norm;
        int  sel, phase;
        // Directed items: basis axes at the quadrant edges, full-scale and zero axes,
        // axes far from unit length that saturate, and the largest phase code.
        add_item( 32767,      0,      0, 16'h0000, 1'b0);
        add_item( 32767,      0,      0, 16'h4000, 1'b0);
        add_item(     0,  32767,      0, 16'h8000, 1'b0);
        add_item(     0,      0,  32767, 16'hC000, 1'b0);
        add_item(-32768,      0,      0, 16'hFFFF, 1'b0);
        add_item(     0, -32768,      0, 16'h0001, 1'b0);
        add_item(     0,      0, -32768, 16'h3FFF, 1'b0);
        add_item( 18919,  18919,  18919, 16'h2000, 1'b0);
        add_item(-18919,  18919, -18919, 16'h5555, 1'b0);
        add_item( 32767,  32767,  32767, 16'h8000, 1'b0);
        add_item(-32768, -32768, -32768, 16'h8000, 1'b0);
        add_item(-32768,  32767, -32768, 16'h4000, 1'b0);
        add_item(     0,      0,      0, 16'h1234, 1'b0);
        add_item( 23170, -23170,      0, 16'hA000, 1'b0);
        add_item(     1,     -1,      1, 16'h7FFF, 1'b0);
        add_item( 32767, -32768,  32767, 16'hC000, 1'b0);
        add_item(-32768, -32768,  32767, 16'hE000, 1'b0);
        add_item( 20000, -15000,  19000, 16'h6000, 1'b0);
        add_item( 32767,      0,      0, 16'h8000, 1'b0);
        add_item(     0,  32767,      0, 16'hBFFF, 1'b0);

        // Random items, with a drain point at the start and in the middle.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sel = $urandom_range(99);
            if ($urandom_range(9) == 0) begin
                phase = ($urandom_range(3) << 14) + $urandom_range(8) - 4;
            end else begin
                phase = $urandom_range(65535);
            end
            if (sel < 70) begin
                // Unit axis of random direction.
                do begin
                    rx = $urandom_range(65535) - 32768.0;
                    ry = $urandom_range(65535) - 32768.0;
                    rz = $urandom_range(65535) - 32768.0;
                    norm = $sqrt(rx * rx + ry * ry + rz * rz);
                end while (norm < 1.0);
                add_item($rtoi(rx * 32767.0 / norm), $rtoi(ry * 32767.0 / norm),
                         $rtoi(rz * 32767.0 / norm), phase, n == 0 || n == 900);
            end else if (sel < 90) begin
                add_item($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                         phase, n == 0 || n == 900);
            end else begin
                add_item(extreme_component(), extreme_component(), extreme_component(),
                         phase, n == 0 || n == 900);
            end
        end
        total_items = axis_queue.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (axis_queue.size() != 0 || i_valid || predicted_matrices.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d axis-angle items and checked %0d matrices, %0d elements saturated.",
                 items_sent, matrices_checked, saturated_elems);
        $display("Mismatches found: %0d.", mismatches);
        if (mismatches == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// ----- axis_angle_rotation_matrix.f -----
design/aarm_pkg.sv
design/aarm_cordic_cell.sv
design/aarm_matrix_tail.sv
design/axis_angle_rotation_matrix.sv
design/aarm_checker.sv
tb/testbench.sv
